FILE: sv/mtt_pkg.sv
// mtt_pkg: types, character codes and the per-byte lexer function of the
// markup tag tokenizer. No dependencies; used by every module of the block.
package mtt_pkg;

    localparam int MAX_RESULTS     = 5;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    typedef enum logic [4:0] {
        MODE_TEXT         = 5'd0,
        MODE_TAG_OPEN     = 5'd1,
        MODE_BANG1        = 5'd2,
        MODE_BANG2        = 5'd3,
        MODE_COMMENT      = 5'd4,
        MODE_END_TAG      = 5'd5,
        MODE_TAG_NAME     = 5'd6,
        MODE_ATTR_GAP     = 5'd7,
        MODE_ATTR_NAME    = 5'd8,
        MODE_VAL_BEFORE_EQ = 5'd9,
        MODE_VAL_AFTER_EQ = 5'd10,
        MODE_VAL_QUOTED   = 5'd11,
        MODE_VAL_BARE     = 5'd12,
        MODE_AFTER_SLASH  = 5'd13
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TEXT    = 3'd0,
        KIND_COMMENT = 3'd1,
        KIND_ENDTAG  = 3'd2,
        KIND_TAGNAME = 3'd3,
        KIND_ANAME   = 3'd4,
        KIND_AVAL    = 3'd5,
        KIND_FIN     = 3'd6,
        KIND_EOF     = 3'd7
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic       ev;
        logic [7:0] ch;
        logic       sc;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        res_t [MAX_RESULTS-1:0]       items;
    } run_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] held_cnt;
        logic [7:0] held0;
        logic [7:0] held1;
        logic       quote_single;
        logic       has_chars;
    } lex_state_t;

    typedef struct packed {
        lex_state_t st;
        run_t       run;
    } step_t;

    localparam lex_state_t LEX_RESET = '{
        mode: MODE_TEXT, held_cnt: 2'd0, held0: 8'd0, held1: 8'd0,
        quote_single: 1'b0, has_chars: 1'b0
    };

    function automatic run_t push(run_t r, tok_kind_t k, logic ev, logic [7:0] ch,
                                  logic sc);
        run_t o;
        res_t e;
        o = r;
        e.kind = k;
        e.ev   = ev;
        e.ch   = ev ? 8'd0 : ch;
        e.sc   = sc;
        if (r.count < CNT_W'(MAX_RESULTS))
        begin
            o.items[r.count] = e;
            o.count = r.count + CNT_W'(1);
        end
        return o;
    endfunction

    function automatic run_t release_held(run_t r, lex_state_t s, tok_kind_t k);
        run_t o;
        o = r;
        if (s.held_cnt >= 2'd1)
            o = push(o, k, 1'b0, s.held0, 1'b0);
        if (s.held_cnt >= 2'd2)
            o = push(o, k, 1'b0, s.held1, 1'b0);
        return o;
    endfunction

    function automatic lex_state_t fin_state(lex_state_t s, logic sc);
        lex_state_t o;
        o = s;
        o.has_chars = 1'b0;
        o.mode = sc ? MODE_AFTER_SLASH : MODE_TEXT;
        return o;
    endfunction

    // One source byte: prefix modes hand the byte on, then the main dispatch,
    // then the end-of-document flush.
    function automatic step_t lex_step(lex_state_t s, logic [7:0] b, logic last);
        lex_state_t n;
        run_t       r;
        logic       go;
        logic       ws;
        logic       qm;
        step_t      o;
        n  = s;
        r  = '0;
        go = 1'b0;
        ws = (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
        qm = n.quote_single ? (b == CH_SQ) : (b == CH_DQ);
        if (b != 8'd0)
        begin
            go = 1'b1;
            unique case (s.mode)
                MODE_TAG_OPEN:
                begin
                    if (b == CH_BANG)
                    begin
                        n.held0 = b; n.held_cnt = 2'd1; n.mode = MODE_BANG1; go = 1'b0;
                    end
                    else if (b == CH_SLASH)
                    begin
                        n.has_chars = 1'b0; n.mode = MODE_END_TAG; go = 1'b0;
                    end
                    else
                        n.mode = MODE_TAG_NAME;
                end
                MODE_BANG1, MODE_BANG2:
                begin
                    if (b == CH_DASH && s.mode == MODE_BANG1)
                    begin
                        n.held1 = b; n.held_cnt = 2'd2; n.mode = MODE_BANG2; go = 1'b0;
                    end
                    else if (b == CH_DASH)
                    begin
                        n.held_cnt = 2'd0; n.mode = MODE_COMMENT; go = 1'b0;
                    end
                    else
                    begin
                        r = release_held(r, n, KIND_TAGNAME);
                        n.held_cnt = 2'd0;
                        n.mode = MODE_TAG_NAME;
                    end
                end
                MODE_VAL_BEFORE_EQ:
                begin
                    if (ws)
                        go = 1'b0;
                    else
                    begin
                        n.mode = MODE_VAL_AFTER_EQ;
                        if (b == CH_EQ)
                            go = 1'b0;
                    end
                end
                MODE_AFTER_SLASH:
                begin
                    n.mode = MODE_TEXT;
                    n.has_chars = 1'b0;
                    if (b == CH_GT)
                        go = 1'b0;
                end
                default: ;
            endcase

            if (go)
            begin
                unique case (n.mode)
                    MODE_COMMENT:
                    begin
                        if (b == CH_DASH)
                        begin
                            if (n.held_cnt < 2'd2)
                            begin
                                if (n.held_cnt == 2'd0)
                                    n.held0 = b;
                                else
                                    n.held1 = b;
                                n.held_cnt = n.held_cnt + 2'd1;
                            end
                            else
                                r = push(r, KIND_COMMENT, 1'b0, CH_DASH, 1'b0);
                        end
                        else if (b == CH_GT && n.held_cnt == 2'd2)
                        begin
                            n.held_cnt = 2'd0;
                            r = push(r, KIND_COMMENT, 1'b1, 8'd0, 1'b0);
                            n.mode = MODE_TEXT;
                        end
                        else
                        begin
                            r = release_held(r, n, KIND_COMMENT);
                            n.held_cnt = 2'd0;
                            r = push(r, KIND_COMMENT, 1'b0, b, 1'b0);
                        end
                    end
                    MODE_END_TAG:
                    begin
                        if (b == CH_GT)
                        begin
                            r = push(r, KIND_ENDTAG, 1'b1, 8'd0, 1'b0);
                            n.mode = MODE_TEXT;
                        end
                        else
                            r = push(r, KIND_ENDTAG, 1'b0, b, 1'b0);
                    end
                    MODE_TAG_NAME:
                    begin
                        if (b == CH_SP || b == CH_TAB || b == CH_LF)
                        begin
                            r = push(r, KIND_TAGNAME, 1'b1, 8'd0, 1'b0);
                            n.mode = MODE_ATTR_GAP;
                        end
                        else if (b == CH_GT || b == CH_SLASH)
                        begin
                            r = push(r, KIND_FIN, 1'b1, 8'd0, b == CH_SLASH);
                            n = fin_state(n, b == CH_SLASH);
                        end
                        else
                            r = push(r, KIND_TAGNAME, 1'b0, b, 1'b0);
                    end
                    MODE_ATTR_GAP:
                    begin
                        if (ws)
                            n.mode = MODE_ATTR_GAP;
                        else if (b == CH_GT || b == CH_SLASH)
                        begin
                            r = push(r, KIND_FIN, 1'b1, 8'd0, b == CH_SLASH);
                            n = fin_state(n, b == CH_SLASH);
                        end
                        else if (b == CH_EQ)
                            n.mode = MODE_VAL_AFTER_EQ;
                        else
                        begin
                            r = push(r, KIND_ANAME, 1'b0, b, 1'b0);
                            n.mode = MODE_ATTR_NAME;
                        end
                    end
                    MODE_ATTR_NAME:
                    begin
                        if (b == CH_EQ || b == CH_SP || b == CH_GT || b == CH_SLASH)
                            r = push(r, KIND_ANAME, 1'b1, 8'd0, 1'b0);
                        if (b == CH_EQ)
                            n.mode = MODE_VAL_AFTER_EQ;
                        else if (b == CH_SP)
                            n.mode = MODE_VAL_BEFORE_EQ;
                        else if (b == CH_GT || b == CH_SLASH)
                        begin
                            r = push(r, KIND_FIN, 1'b1, 8'd0, b == CH_SLASH);
                            n = fin_state(n, b == CH_SLASH);
                        end
                        else
                            r = push(r, KIND_ANAME, 1'b0, b, 1'b0);
                    end
                    MODE_VAL_AFTER_EQ:
                    begin
                        if (ws)
                            n.mode = MODE_VAL_AFTER_EQ;
                        else if (b == CH_DQ || b == CH_SQ)
                        begin
                            n.quote_single = (b == CH_SQ);
                            n.has_chars = 1'b0;
                            n.mode = MODE_VAL_QUOTED;
                        end
                        else if (b == CH_GT || b == CH_SLASH)
                        begin
                            r = push(r, KIND_FIN, 1'b1, 8'd0, b == CH_SLASH);
                            n = fin_state(n, b == CH_SLASH);
                        end
                        else
                        begin
                            r = push(r, KIND_AVAL, 1'b0, b, 1'b0);
                            n.has_chars = 1'b1;
                            n.mode = MODE_VAL_BARE;
                        end
                    end
                    MODE_VAL_QUOTED:
                    begin
                        if (qm)
                        begin
                            if (n.has_chars)
                                r = push(r, KIND_AVAL, 1'b1, 8'd0, 1'b0);
                            n.has_chars = 1'b0;
                            n.mode = MODE_ATTR_GAP;
                        end
                        else
                        begin
                            r = push(r, KIND_AVAL, 1'b0, b, 1'b0);
                            n.has_chars = 1'b1;
                        end
                    end
                    MODE_VAL_BARE:
                    begin
                        if (b == CH_SP || b == CH_GT || b == CH_SLASH)
                            r = push(r, KIND_AVAL, 1'b1, 8'd0, 1'b0);
                        if (b == CH_SP)
                        begin
                            n.has_chars = 1'b0;
                            n.mode = MODE_ATTR_GAP;
                        end
                        else if (b == CH_GT || b == CH_SLASH)
                        begin
                            r = push(r, KIND_FIN, 1'b1, 8'd0, b == CH_SLASH);
                            n = fin_state(n, b == CH_SLASH);
                        end
                        else
                            r = push(r, KIND_AVAL, 1'b0, b, 1'b0);
                    end
                    default:
                    begin
                        n.mode = MODE_TEXT;
                        if (b == CH_LT)
                        begin
                            if (n.has_chars)
                                r = push(r, KIND_TEXT, 1'b1, 8'd0, 1'b0);
                            n.has_chars = 1'b0;
                            n.mode = MODE_TAG_OPEN;
                        end
                        else
                        begin
                            r = push(r, KIND_TEXT, 1'b0, b, 1'b0);
                            n.has_chars = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (b == 8'd0 || last)
        begin
            unique case (n.mode)
                MODE_TAG_OPEN, MODE_TAG_NAME, MODE_ATTR_GAP, MODE_VAL_BEFORE_EQ,
                MODE_VAL_AFTER_EQ:
                    r = push(r, KIND_FIN, 1'b1, 8'd0, 1'b0);
                MODE_BANG1, MODE_BANG2:
                begin
                    r = release_held(r, n, KIND_TAGNAME);
                    r = push(r, KIND_FIN, 1'b1, 8'd0, 1'b0);
                end
                MODE_COMMENT:
                begin
                    r = release_held(r, n, KIND_COMMENT);
                    r = push(r, KIND_COMMENT, 1'b1, 8'd0, 1'b0);
                end
                MODE_END_TAG:
                    r = push(r, KIND_ENDTAG, 1'b1, 8'd0, 1'b0);
                MODE_ATTR_NAME:
                begin
                    r = push(r, KIND_ANAME, 1'b1, 8'd0, 1'b0);
                    r = push(r, KIND_FIN, 1'b1, 8'd0, 1'b0);
                end
                MODE_VAL_QUOTED:
                begin
                    if (n.has_chars)
                        r = push(r, KIND_AVAL, 1'b1, 8'd0, 1'b0);
                    r = push(r, KIND_FIN, 1'b1, 8'd0, 1'b0);
                end
                MODE_VAL_BARE:
                begin
                    r = push(r, KIND_AVAL, 1'b1, 8'd0, 1'b0);
                    r = push(r, KIND_FIN, 1'b1, 8'd0, 1'b0);
                end
                MODE_AFTER_SLASH: ;
                default:
                begin
                    if (n.has_chars)
                        r = push(r, KIND_TEXT, 1'b1, 8'd0, 1'b0);
                end
            endcase
            r = push(r, KIND_EOF, 1'b1, 8'd0, 1'b0);
            n = LEX_RESET;
        end

        o.st  = n;
        o.run = r;
        return o;
    endfunction

endpackage

FILE: sv/mtt_front.sv
// mtt_front: accepts source bytes, runs the lexer and writes each byte's
// results as one run into the queue. Depends on mtt_pkg.
module mtt_front
    import mtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       q_full,
    output logic       q_wr,
    output run_t       q_wr_data
);

    lex_state_t lex_reg;
    step_t      step;
    logic       accept;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    always_comb
    begin
        step      = lex_step(lex_reg, data_byte, end_of_input);
        q_wr_data = step.run;
        q_wr      = accept && (step.run.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lex_reg <= LEX_RESET;
        else if (accept)
            lex_reg <= step.st;
    end

endmodule

FILE: sv/mtt_queue.sv
// mtt_queue: short register queue of result runs between front and back.
// Depends on mtt_pkg.
module mtt_queue
    import mtt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  run_t wr_data,
    output logic full,
    input  logic rd,
    output run_t rd_data,
    output logic not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    run_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full      = (cnt_reg == CNT_QW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_QW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/mtt_back.sv
// mtt_back: walks the run at the queue head and issues one result per cycle
// through the output register while token_stall is low. Depends on mtt_pkg.
module mtt_back
    import mtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       token_valid,
    input  logic       token_stall,
    output logic [2:0] token_kind,
    output logic       event_kind,
    output logic [7:0] char_out,
    output logic       self_closing,
    output logic       last_of_run
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    res_t             res_reg;
    logic             last_reg;
    logic             load;
    logic             is_last;

    assign load    = head_valid && (!valid_reg || !token_stall);
    assign is_last = (idx_reg == head.count - CNT_W'(1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? '0 : idx_reg + CNT_W'(1);
            valid_next = 1'b1;
        end
        else if (!token_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.items[idx_reg];
            last_reg <= is_last;
        end
    end

    assign token_valid  = valid_reg;
    assign token_kind   = res_reg.kind;
    assign event_kind   = res_reg.ev;
    assign char_out     = res_reg.ch;
    assign self_closing = res_reg.sc;
    assign last_of_run  = last_reg;

endmodule

FILE: sv/markup_tag_tokenizer.sv
// markup_tag_tokenizer: top level; lexer front, run queue, result back end.
// Depends on mtt_pkg, mtt_front, mtt_queue, mtt_back.
//
// channel | valid       | stall       | payload
// --------+-------------+-------------+------------------------------------------
// byte in | byte_valid  | byte_stall  | data_byte, end_of_input
// token   | token_valid | token_stall | token_kind, event_kind, char_out,
//         |             |             | self_closing, last_of_run
//
// One byte is taken per cycle while the run queue has room; a byte yields 0..5
// results and the back end issues one result per cycle while token_stall is low,
// so bytes flow at one per cycle as long as they average at most one result each.
// byte_stall rises only when the queue (QUEUE_DEPTH runs) is full. Reset puts the
// lexer in text mode and empties queue and output.
module markup_tag_tokenizer
    import mtt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       token_valid,
    input  logic       token_stall,
    output logic [2:0] token_kind,
    output logic       event_kind,
    output logic [7:0] char_out,
    output logic       self_closing,
    output logic       last_of_run
);

    logic q_full;
    logic q_wr;
    run_t q_wr_data;
    logic q_rd;
    run_t q_head;
    logic q_not_empty;

    mtt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_wr_data    (q_wr_data)
    );

    mtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .rd        (q_rd),
        .rd_data   (q_head),
        .not_empty (q_not_empty)
    );

    mtt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_not_empty),
        .pop          (q_rd),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .event_kind   (event_kind),
        .char_out     (char_out),
        .self_closing (self_closing),
        .last_of_run  (last_of_run)
    );

endmodule

FILE: test/tb_markup_tag_tokenizer.sv
// Testbench for markup_tag_tokenizer: streams directed and random markup documents,
// predicts every token transaction in a scoreboard class and checks the output.
// Depends on mtt_pkg and the markup_tag_tokenizer RTL.
`timescale 1ns / 1ps

import mtt_pkg::*;

typedef struct {
    tok_kind_t  kind;
    bit         ev;
    bit [7:0]   ch;
    bit         sc;
    bit         last;
} token_t;

class token_scoreboard;
    mode_t      lex_mode;
    bit [1:0]   held_cnt;
    bit [7:0]   held_buf [2];
    bit         quote_single;
    bit         has_chars;
    token_t     run_tokens[$];
    token_t     expected_tokens[$];
    int         mismatches;
    int         tokens_checked;
    int         bytes_noted;
    int         docs_closed;

    function new();
        clear_lexer();
        mismatches = 0;
        tokens_checked = 0;
        bytes_noted = 0;
        docs_closed = 0;
    endfunction

    function void clear_lexer();
        lex_mode = MODE_TEXT;
        held_cnt = 2'd0;
        held_buf[0] = 8'd0;
        held_buf[1] = 8'd0;
        quote_single = 1'b0;
        has_chars = 1'b0;
    endfunction

    function void add_token(tok_kind_t kind, bit ev, bit [7:0] ch, bit sc);
        token_t t;
        if (run_tokens.size() >= MAX_RESULTS)
            return;
        t.kind = kind;
        t.ev   = ev;
        t.ch   = ev ? 8'd0 : ch;
        t.sc   = sc;
        t.last = 1'b0;
        run_tokens.push_back(t);
    endfunction

    function void flush_held(tok_kind_t kind);
        for (int i = 0; i < int'(held_cnt); i++)
            add_token(kind, 1'b0, held_buf[i], 1'b0);
        held_cnt = 2'd0;
    endfunction

    function void close_tag(bit sc);
        add_token(KIND_FIN, 1'b1, 8'd0, sc);
        has_chars = 1'b0;
        lex_mode = sc ? MODE_AFTER_SLASH : MODE_TEXT;
    endfunction

    function bit is_space(bit [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    // prefix modes hand the byte on to the mode they switch to
    function void lex_byte(bit [7:0] b);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (lex_mode)
                MODE_TAG_OPEN:
                begin
                    if (b == CH_BANG)
                    begin
                        held_buf[0] = b;
                        held_cnt = 2'd1;
                        lex_mode = MODE_BANG1;
                    end
                    else if (b == CH_SLASH)
                    begin
                        has_chars = 1'b0;
                        lex_mode = MODE_END_TAG;
                    end
                    else
                    begin
                        lex_mode = MODE_TAG_NAME;
                        again = 1'b1;
                    end
                end
                MODE_BANG1, MODE_BANG2:
                begin
                    if (b == CH_DASH && lex_mode == MODE_BANG1)
                    begin
                        held_buf[1] = b;
                        held_cnt = 2'd2;
                        lex_mode = MODE_BANG2;
                    end
                    else if (b == CH_DASH)
                    begin
                        held_cnt = 2'd0;
                        lex_mode = MODE_COMMENT;
                    end
                    else
                    begin
                        flush_held(KIND_TAGNAME);
                        lex_mode = MODE_TAG_NAME;
                        again = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (b == CH_DASH)
                    begin
                        if (held_cnt < 2'd2)
                        begin
                            held_buf[held_cnt] = b;
                            held_cnt++;
                        end
                        else
                            add_token(KIND_COMMENT, 1'b0, CH_DASH, 1'b0);
                    end
                    else if (b == CH_GT && held_cnt == 2'd2)
                    begin
                        held_cnt = 2'd0;
                        add_token(KIND_COMMENT, 1'b1, 8'd0, 1'b0);
                        lex_mode = MODE_TEXT;
                    end
                    else
                    begin
                        flush_held(KIND_COMMENT);
                        add_token(KIND_COMMENT, 1'b0, b, 1'b0);
                    end
                end
                MODE_END_TAG:
                begin
                    if (b == CH_GT)
                    begin
                        add_token(KIND_ENDTAG, 1'b1, 8'd0, 1'b0);
                        lex_mode = MODE_TEXT;
                    end
                    else
                        add_token(KIND_ENDTAG, 1'b0, b, 1'b0);
                end
                MODE_TAG_NAME:
                begin
                    // carriage return stays part of the name
                    if (b == CH_SP || b == CH_TAB || b == CH_LF)
                    begin
                        add_token(KIND_TAGNAME, 1'b1, 8'd0, 1'b0);
                        lex_mode = MODE_ATTR_GAP;
                    end
                    else if (b == CH_GT)
                        close_tag(1'b0);
                    else if (b == CH_SLASH)
                        close_tag(1'b1);
                    else
                        add_token(KIND_TAGNAME, 1'b0, b, 1'b0);
                end
                MODE_ATTR_GAP:
                begin
                    if (!is_space(b))
                    begin
                        if (b == CH_GT)
                            close_tag(1'b0);
                        else if (b == CH_SLASH)
                            close_tag(1'b1);
                        else if (b == CH_EQ)
                            lex_mode = MODE_VAL_AFTER_EQ;
                        else
                        begin
                            add_token(KIND_ANAME, 1'b0, b, 1'b0);
                            lex_mode = MODE_ATTR_NAME;
                        end
                    end
                end
                MODE_ATTR_NAME:
                begin
                    if (b == CH_EQ || b == CH_SP || b == CH_GT || b == CH_SLASH)
                        add_token(KIND_ANAME, 1'b1, 8'd0, 1'b0);
                    if (b == CH_EQ)
                        lex_mode = MODE_VAL_AFTER_EQ;
                    else if (b == CH_SP)
                        lex_mode = MODE_VAL_BEFORE_EQ;
                    else if (b == CH_GT)
                        close_tag(1'b0);
                    else if (b == CH_SLASH)
                        close_tag(1'b1);
                    else
                        add_token(KIND_ANAME, 1'b0, b, 1'b0);
                end
                MODE_VAL_BEFORE_EQ:
                begin
                    if (!is_space(b))
                    begin
                        lex_mode = MODE_VAL_AFTER_EQ;
                        again = (b != CH_EQ);
                    end
                end
                MODE_VAL_AFTER_EQ:
                begin
                    if (!is_space(b))
                    begin
                        if (b == CH_DQ || b == CH_SQ)
                        begin
                            quote_single = (b == CH_SQ);
                            has_chars = 1'b0;
                            lex_mode = MODE_VAL_QUOTED;
                        end
                        else if (b == CH_GT)
                            close_tag(1'b0);
                        else if (b == CH_SLASH)
                            close_tag(1'b1);
                        else
                        begin
                            add_token(KIND_AVAL, 1'b0, b, 1'b0);
                            has_chars = 1'b1;
                            lex_mode = MODE_VAL_BARE;
                        end
                    end
                end
                MODE_VAL_QUOTED:
                begin
                    if (b == (quote_single ? CH_SQ : CH_DQ))
                    begin
                        if (has_chars)
                            add_token(KIND_AVAL, 1'b1, 8'd0, 1'b0);
                        has_chars = 1'b0;
                        lex_mode = MODE_ATTR_GAP;
                    end
                    else
                    begin
                        add_token(KIND_AVAL, 1'b0, b, 1'b0);
                        has_chars = 1'b1;
                    end
                end
                MODE_VAL_BARE:
                begin
                    if (b == CH_SP || b == CH_GT || b == CH_SLASH)
                        add_token(KIND_AVAL, 1'b1, 8'd0, 1'b0);
                    if (b == CH_SP)
                    begin
                        has_chars = 1'b0;
                        lex_mode = MODE_ATTR_GAP;
                    end
                    else if (b == CH_GT)
                        close_tag(1'b0);
                    else if (b == CH_SLASH)
                        close_tag(1'b1);
                    else
                        add_token(KIND_AVAL, 1'b0, b, 1'b0);
                end
                MODE_AFTER_SLASH:
                begin
                    lex_mode = MODE_TEXT;
                    has_chars = 1'b0;
                    again = (b != CH_GT);
                end
                default:
                begin
                    lex_mode = MODE_TEXT;
                    if (b == CH_LT)
                    begin
                        if (has_chars)
                            add_token(KIND_TEXT, 1'b1, 8'd0, 1'b0);
                        has_chars = 1'b0;
                        lex_mode = MODE_TAG_OPEN;
                    end
                    else
                    begin
                        add_token(KIND_TEXT, 1'b0, b, 1'b0);
                        has_chars = 1'b1;
                    end
                end
            endcase
        end
    endfunction

    function void end_document();
        case (lex_mode)
            MODE_TAG_OPEN, MODE_TAG_NAME, MODE_ATTR_GAP, MODE_VAL_BEFORE_EQ,
            MODE_VAL_AFTER_EQ:
                close_tag(1'b0);
            MODE_BANG1, MODE_BANG2:
            begin
                flush_held(KIND_TAGNAME);
                close_tag(1'b0);
            end
            MODE_COMMENT:
            begin
                flush_held(KIND_COMMENT);
                add_token(KIND_COMMENT, 1'b1, 8'd0, 1'b0);
            end
            MODE_END_TAG:
                add_token(KIND_ENDTAG, 1'b1, 8'd0, 1'b0);
            MODE_ATTR_NAME:
            begin
                add_token(KIND_ANAME, 1'b1, 8'd0, 1'b0);
                close_tag(1'b0);
            end
            MODE_VAL_QUOTED:
            begin
                if (has_chars)
                    add_token(KIND_AVAL, 1'b1, 8'd0, 1'b0);
                close_tag(1'b0);
            end
            MODE_VAL_BARE:
            begin
                add_token(KIND_AVAL, 1'b1, 8'd0, 1'b0);
                close_tag(1'b0);
            end
            MODE_AFTER_SLASH: ;
            default:
            begin
                if (has_chars)
                    add_token(KIND_TEXT, 1'b1, 8'd0, 1'b0);
            end
        endcase
        add_token(KIND_EOF, 1'b1, 8'd0, 1'b0);
        clear_lexer();
        docs_closed++;
    endfunction

    function void note_byte(bit [7:0] b, bit eoi);
        run_tokens.delete();
        bytes_noted++;
        if (b != 8'd0)
            lex_byte(b);
        if (b == 8'd0 || eoi)
            end_document();
        if (run_tokens.size() > 0)
            run_tokens[run_tokens.size() - 1].last = 1'b1;
        foreach (run_tokens[i])
            expected_tokens.push_back(run_tokens[i]);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH %0t: %s", $realtime, msg);
    endtask

    task check_token(logic [2:0] kind, logic ev, logic [7:0] ch, logic sc, logic last);
        token_t t;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token kind %0d ev %0b ch %02h",
                                      kind, ev, ch));
            return;
        end
        t = expected_tokens.pop_front();
        if (kind !== t.kind || ev !== t.ev || ch !== t.ch || sc !== t.sc || last !== t.last)
            report_mismatch($sformatf(
                "token %0d: got %0d/%0b/%02h/%0b/%0b, want %0d/%0b/%02h/%0b/%0b",
                tokens_checked, kind, ev, ch, sc, last, t.kind, t.ev, t.ch, t.sc, t.last));
        tokens_checked++;
    endtask
endclass

module tb_markup_tag_tokenizer;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES   = 85;

    typedef struct {
        bit [7:0] data;
        bit       eoi;
    } src_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte = 8'd0;
    logic       end_of_input = 1'b0;
    logic       token_valid;
    logic       token_stall = 1'b0;
    logic [2:0] token_kind;
    logic       event_kind;
    logic [7:0] char_out;
    logic       self_closing;
    logic       last_of_run;
    logic       holding = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    token_scoreboard sb;
    bit [7:0]        frag[$];
    src_byte_t       byte_plan[$];

    markup_tag_tokenizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .event_kind   (event_kind),
        .char_out     (char_out),
        .self_closing (self_closing),
        .last_of_run  (last_of_run)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        token_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                sb.note_byte(data_byte, end_of_input);
            if (token_valid && !token_stall)
                sb.check_token(token_kind, event_kind, char_out, self_closing,
                               last_of_run);
        end
    end

    function automatic bit [7:0] pick_char(bit wide);
        if (wide && $urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic void put_word(int lo, int hi, bit wide);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n)
            frag.push_back(pick_char(wide));
    endfunction

    function automatic void put_space();
        case ($urandom_range(0, 5))
            0: frag.push_back(CH_TAB);
            1: frag.push_back(CH_LF);
            2: frag.push_back(CH_CR);
            default: frag.push_back(CH_SP);
        endcase
    endfunction

    function automatic void put_value();
        case ($urandom_range(0, 4))
            0:
            begin
                frag.push_back(CH_DQ);
                put_word(0, 4, 1'b1);
                frag.push_back(CH_DQ);
            end
            1:
            begin
                frag.push_back(CH_SQ);
                put_word(0, 4, 1'b1);
                frag.push_back(CH_SQ);
            end
            2:
            begin
                frag.push_back(CH_DQ);
                frag.push_back(CH_DQ);
            end
            default: put_word(1, 4, 1'b0);
        endcase
    endfunction

    function automatic void put_tag();
        int sep;
        frag.push_back(CH_LT);
        case ($urandom_range(0, 9))
            0: frag.push_back(CH_BANG);
            1:
            begin
                frag.push_back(CH_BANG);
                frag.push_back(CH_DASH);
            end
            default: ;
        endcase
        put_word(0, 4, 1'b1);
        repeat ($urandom_range(0, 3))
        begin
            put_space();
            if ($urandom_range(0, 3) == 0)
                put_space();
            put_word(1, 3, $urandom_range(0, 4) == 0);
            sep = $urandom_range(0, 4);
            case (sep)
                1:
                begin
                    frag.push_back(CH_SP);
                    frag.push_back(CH_EQ);
                    frag.push_back(CH_SP);
                end
                2: frag.push_back(CH_SP);
                3: ;
                default: frag.push_back(CH_EQ);
            endcase
            if (sep != 3)
                put_value();
        end
        case ($urandom_range(0, 5))
            2:
            begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_GT);
            end
            3:
            begin
                frag.push_back(CH_SLASH);
                frag.push_back(pick_char(1'b1));
            end
            4:
            begin
                frag.push_back(CH_SP);
                frag.push_back(CH_GT);
            end
            5: frag.push_back(CH_SLASH);
            default: frag.push_back(CH_GT);
        endcase
    endfunction

    function automatic void put_comment();
        frag.push_back(CH_LT);
        frag.push_back(CH_BANG);
        frag.push_back(CH_DASH);
        frag.push_back(CH_DASH);
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 3))
                0: frag.push_back(CH_DASH);
                1: frag.push_back(CH_GT);
                default: frag.push_back(pick_char(1'b1));
            endcase
        end
        if ($urandom_range(0, 4) != 0)
            frag.push_back(CH_DASH);
        frag.push_back(CH_DASH);
        frag.push_back(CH_GT);
    endfunction

    function automatic void put_end_tag();
        frag.push_back(CH_LT);
        frag.push_back(CH_SLASH);
        put_word(0, 4, 1'b1);
        frag.push_back(CH_GT);
    endfunction

    // one document of mostly well-formed markup, sometimes cut short
    function automatic void make_doc();
        int cut;
        frag.delete();
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_tag();
                4: put_end_tag();
                7: put_comment();
                8:
                begin
                    repeat ($urandom_range(1, 3))
                        frag.push_back(8'($urandom_range(0, 255)));
                end
                default: put_word(1, 6, 1'b1);
            endcase
        end
        if ($urandom_range(0, 3) == 0 && frag.size() > 1)
        begin
            cut = $urandom_range(frag.size() - 1, 1);
            while (frag.size() > cut)
                void'(frag.pop_back());
        end
        foreach (frag[i])
            byte_plan.push_back('{frag[i], 1'b0});
        case ($urandom_range(0, 2))
            0: byte_plan.push_back('{8'd0, 1'b0});
            1: byte_plan[byte_plan.size() - 1].eoi = 1'b1;
            default: byte_plan.push_back('{8'($urandom_range(1, 255)), 1'b1});
        endcase
    endfunction

    function automatic void plan_str(string s, bit eoi_last);
        foreach (s[i])
            byte_plan.push_back('{8'(s[i]), eoi_last && i == s.len() - 1});
    endfunction

    task automatic send_byte(bit [7:0] d, bit eoi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= d;
        end_of_input <= eoi;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic run_plan();
        src_byte_t item;
        while (byte_plan.size() > 0)
        begin
            item = byte_plan.pop_front();
            send_byte(item.data, item.eoi);
            bytes_sent++;
        end
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic hold_off(int cycles);
        holding <= 1'b1;
        repeat (cycles) @(posedge clk);
        holding <= 1'b0;
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit pressure);
        int target;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = bytes_sent + PHASE_BYTES;
        if (pressure)
            fork
                hold_off(150);
            join_none
        while (bytes_sent < target)
        begin
            make_doc();
            run_plan();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_str("a<!--b-->", 1'b0);
        plan_str("</>", 1'b0);
        plan_str("<t\r k v/>", 1'b0);
        byte_plan.push_back('{8'hFF, 1'b0});
        byte_plan.push_back('{8'h00, 1'b0});
        plan_str("<!-x", 1'b1);
        run_plan();
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(77, 0, 1'b0);
        run_phase(0, 77, 1'b0);
        run_phase(32, 32, 1'b0);

        $display("Streamed %0d bytes in %0d documents; %0d tokens checked, %0d mismatches.",
                 sb.bytes_noted, sb.docs_closed, sb.tokens_checked, sb.mismatches);
        $display("Idling covered: none, sender, receiver, both, and a long output hold-off.");
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/mtt_pkg.sv
sv/mtt_front.sv
sv/mtt_queue.sv
sv/mtt_back.sv
sv/markup_tag_tokenizer.sv
test/tb_markup_tag_tokenizer.sv
